// ----- rtl/core/prescaled_reload_timer_bank_unit_defines.svh -----
// Assertion macros used by the timer bank controller.
`ifndef PRESCALED_RELOAD_TIMER_BANK_UNIT_DEFINES_SVH
`define PRESCALED_RELOAD_TIMER_BANK_UNIT_DEFINES_SVH

// Checks that a condition implies a consequence in the same cycle.
`define PRTB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Checks that a condition implies a consequence in the next cycle.
`define PRTB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/prtb_pkg.sv -----
// ---------------------------------------------------------------------------
// prtb_pkg
// Shared types and constants of the prescaled reload timer bank.
// ---------------------------------------------------------------------------
package prtb_pkg;

    localparam int NumTimersDefault = 4;

    localparam logic [2:0] MODE_ADVANCE   = 3'd0;
    localparam logic [2:0] MODE_CONFIGURE = 3'd1;
    localparam logic [2:0] MODE_ENABLE    = 3'd2;
    localparam logic [2:0] MODE_PRESCALE  = 3'd3;
    localparam logic [2:0] MODE_RESET     = 3'd4;
    localparam logic [2:0] MODE_READ      = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;      // capture the item and apply its direct updates
        logic       div_start; // start dividing for the current timer
        logic       commit;    // apply the quotient to the current timer
        logic       next_tmr;  // step to the next timer
        logic       out_load;  // load the result register
    } prtb_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic adv;        // captured item is an advance with the bank running
        logic last_tmr;   // current timer is the last one
    } prtb_sts_t;

endpackage

// ----- rtl/core/prtb_ctrl.sv -----
// ---------------------------------------------------------------------------
// prtb_ctrl
// Sequencer: accepts an item, walks advance items through the timers.
// ---------------------------------------------------------------------------
`include "prescaled_reload_timer_bank_unit_defines.svh"
module prtb_ctrl import prtb_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output prtb_cmd_t cmd,
    input  prtb_sts_t sts
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_DIV = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       mv_reg, mv_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mv_reg;

    always_comb begin
        state_next = state_reg;
        mv_next = mv_reg;
        cmd = '0;
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (sts.adv) begin
                    cmd.div_start = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (!sts.div_busy) begin
                    cmd.commit = 1'b1;
                    if (sts.last_tmr) begin
                        state_next = ST_DONE;
                    end else begin
                        cmd.next_tmr = 1'b1;
                        state_next = ST_DECODE;
                    end
                end
            end
            ST_DONE: begin
                if (!mv_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    mv_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg <= mv_next;
        end
    end

    `PRTB_ASSERT_IMP(a_load_idle, aclk, aresetn, cmd.load, state_reg == ST_IDLE)
    `PRTB_ASSERT_NEXT(a_out_valid, aclk, aresetn, cmd.out_load, m_valid)
    `PRTB_ASSERT_IMP(a_commit_ready, aclk, aresetn, cmd.commit, !sts.div_busy)
endmodule

// ----- rtl/core/prtb_div.sv -----
// ---------------------------------------------------------------------------
// prtb_div
// Radix-2 restoring divider, 32-bit dividend by 16-bit divisor.
// ---------------------------------------------------------------------------
module prtb_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        busy,
    output logic [31:0] quotient
);
    logic [5:0]  cnt_reg;
    logic [31:0] q_reg;
    logic [16:0] rem_reg;
    logic [15:0] dsr_reg;
    logic [16:0] trial;
    logic [16:0] shifted;

    assign busy = (cnt_reg != 6'd0);
    assign quotient = q_reg;
    assign shifted = {rem_reg[15:0], q_reg[31]};
    assign trial = shifted - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 6'd0;
        end else if (start) begin
            cnt_reg <= 6'd32;
        end else if (busy) begin
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= (divisor == 16'd0) ? 16'd1 : divisor;
        end else if (busy) begin
            if (!trial[16]) begin
                rem_reg <= trial;
                q_reg <= {q_reg[30:0], 1'b1};
            end else begin
                rem_reg <= shifted;
                q_reg <= {q_reg[30:0], 1'b0};
            end
        end
    end
endmodule

// ----- rtl/core/prtb_dp.sv -----
// ---------------------------------------------------------------------------
// prtb_dp
// Timer state, item register, per-timer update and result register.
// ---------------------------------------------------------------------------
module prtb_dp import prtb_pkg::*; #(
    parameter int NUM_TIMERS = NumTimersDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        global_run,
    input  logic [2:0]  s_mode,
    input  logic [2:0]  s_timer_index,
    input  logic [31:0] s_elapsed_cycles,
    input  logic [31:0] s_period_value,
    input  logic [15:0] s_prescale_value,
    input  logic        s_enable_flag,
    input  prtb_cmd_t   cmd,
    output prtb_sts_t   sts,
    output logic [7:0]  m_fired_mask,
    output logic [31:0] m_counter_value,
    output logic [31:0] m_period_out,
    output logic [31:0] m_reload_out,
    output logic [15:0] m_prescale_out,
    output logic        m_expired_out,
    output logic        m_timer_on_out,
    output logic [63:0] m_cycle_total
);
    localparam int TW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    logic [31:0] count_reg [NUM_TIMERS];
    logic [31:0] period_reg [NUM_TIMERS];
    logic [31:0] reload_reg [NUM_TIMERS];
    logic [15:0] prescale_reg [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] on_reg, exp_reg;
    logic [63:0] total_reg;
    logic [2:0]  mode_reg, idx_reg;
    logic [31:0] cyc_reg;
    logic        run_reg;
    logic [TW-1:0] tmr_reg;
    logic [7:0]  mask_reg;

    logic        ok;
    logic [TW-1:0] idx_w;
    logic        div_busy;
    logic [31:0] quot, sum, prev;
    logic        active;

    assign ok = ({29'd0, idx_reg} < 32'(NUM_TIMERS));
    assign idx_w = idx_reg[TW-1:0];
    assign prev = count_reg[tmr_reg];
    assign sum = prev + quot;
    assign active = on_reg[tmr_reg] && (period_reg[tmr_reg] != 32'd0);

    assign sts.div_busy = div_busy;
    assign sts.adv = (mode_reg == MODE_ADVANCE) && run_reg;
    assign sts.last_tmr = (32'(tmr_reg) == 32'(NUM_TIMERS - 1));

    prtb_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (cyc_reg),
        .divisor  (prescale_reg[tmr_reg]),
        .busy     (div_busy),
        .quotient (quot)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= s_mode;
            idx_reg <= s_timer_index;
            cyc_reg <= s_elapsed_cycles;
            run_reg <= global_run;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int t = 0; t < NUM_TIMERS; t++) begin
                count_reg[t] <= '0;
                period_reg[t] <= '0;
                reload_reg[t] <= '0;
                prescale_reg[t] <= 16'd1;
            end
            on_reg <= '0;
            exp_reg <= '0;
            total_reg <= '0;
            tmr_reg <= '0;
            mask_reg <= '0;
        end else if (cmd.load) begin
            tmr_reg <= '0;
            mask_reg <= '0;
            if (s_mode == MODE_ADVANCE && global_run) begin
                total_reg <= total_reg + {32'd0, s_elapsed_cycles};
            end
            if (s_mode == MODE_RESET) begin
                total_reg <= '0;
                for (int t = 0; t < NUM_TIMERS; t++) begin
                    count_reg[t] <= reload_reg[t];
                end
                exp_reg <= '0;
            end
            if ({29'd0, s_timer_index} < 32'(NUM_TIMERS)) begin
                case (s_mode)
                    MODE_CONFIGURE: begin
                        period_reg[s_timer_index[TW-1:0]] <= s_period_value;
                        reload_reg[s_timer_index[TW-1:0]] <= s_period_value;
                        count_reg[s_timer_index[TW-1:0]] <= '0;
                        on_reg[s_timer_index[TW-1:0]] <= 1'b1;
                        exp_reg[s_timer_index[TW-1:0]] <= 1'b0;
                    end
                    MODE_ENABLE: begin
                        on_reg[s_timer_index[TW-1:0]] <= s_enable_flag;
                        if (s_enable_flag) begin
                            count_reg[s_timer_index[TW-1:0]] <=
                                reload_reg[s_timer_index[TW-1:0]];
                            exp_reg[s_timer_index[TW-1:0]] <= 1'b0;
                        end
                    end
                    MODE_PRESCALE: begin
                        prescale_reg[s_timer_index[TW-1:0]] <= s_prescale_value;
                    end
                    default: ;
                endcase
            end
        end else begin
            if (cmd.commit && active) begin
                if (sum >= period_reg[tmr_reg]) begin
                    exp_reg[tmr_reg] <= 1'b1;
                    count_reg[tmr_reg] <= reload_reg[tmr_reg];
                    mask_reg[tmr_reg] <= 1'b1;
                end else if (sum < prev) begin
                    count_reg[tmr_reg] <= period_reg[tmr_reg] - 32'd1;
                end else begin
                    count_reg[tmr_reg] <= sum;
                end
            end
            if (cmd.next_tmr) begin
                tmr_reg <= tmr_reg + TW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_fired_mask <= (mode_reg == MODE_ADVANCE) ? mask_reg : 8'd0;
            m_cycle_total <= total_reg;
            if (mode_reg == MODE_READ && ok) begin
                m_counter_value <= count_reg[idx_w];
                m_period_out <= period_reg[idx_w];
                m_reload_out <= reload_reg[idx_w];
                m_prescale_out <= prescale_reg[idx_w];
                m_expired_out <= exp_reg[idx_w];
                m_timer_on_out <= on_reg[idx_w];
            end else begin
                m_counter_value <= '0;
                m_period_out <= '0;
                m_reload_out <= '0;
                m_prescale_out <= '0;
                m_expired_out <= 1'b0;
                m_timer_on_out <= 1'b0;
            end
        end
    end
endmodule

// ----- rtl/core/prescaled_reload_timer_bank_unit.sv -----
// ---------------------------------------------------------------------------
// prescaled_reload_timer_bank_unit
// Bank of interval timers with per-timer prescaler, period and reload.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  mode, index, elapsed, period, ...
// m_        out        m_valid / m_ready  fired mask, read fields, total
//
// A non-advance item takes the controller through its accept, decode and
// done steps. An advance item with the bank running instead goes, for each
// timer in turn, through a decode, a start and a wait step on the shared
// 32-step serial divider before its done step. Reset is synchronous and active
// low. While a result is held, one more transfer is taken and processed, and
// the controller then waits in its final step until the result register frees.
module prescaled_reload_timer_bank_unit import prtb_pkg::*; #(
    parameter int NUM_TIMERS = NumTimersDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [2:0]  s_timer_index,
    input  logic [31:0] s_elapsed_cycles,
    input  logic [31:0] s_period_value,
    input  logic [15:0] s_prescale_value,
    input  logic        s_enable_flag,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_fired_mask,
    output logic [31:0] m_counter_value,
    output logic [31:0] m_period_out,
    output logic [31:0] m_reload_out,
    output logic [15:0] m_prescale_out,
    output logic        m_expired_out,
    output logic        m_timer_on_out,
    output logic [63:0] m_cycle_total
);
    prtb_cmd_t cmd;
    prtb_sts_t sts;
    logic      run_reg;

    // The run bit gates advance items; it resets to running.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b1;
        end else if (cfg_we) begin
            run_reg <= cfg_wdata;
        end
    end

    prtb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    prtb_dp #(.NUM_TIMERS(NUM_TIMERS)) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .global_run       (run_reg),
        .s_mode           (s_mode),
        .s_timer_index    (s_timer_index),
        .s_elapsed_cycles (s_elapsed_cycles),
        .s_period_value   (s_period_value),
        .s_prescale_value (s_prescale_value),
        .s_enable_flag    (s_enable_flag),
        .cmd              (cmd),
        .sts              (sts),
        .m_fired_mask     (m_fired_mask),
        .m_counter_value  (m_counter_value),
        .m_period_out     (m_period_out),
        .m_reload_out     (m_reload_out),
        .m_prescale_out   (m_prescale_out),
        .m_expired_out    (m_expired_out),
        .m_timer_on_out   (m_timer_on_out),
        .m_cycle_total    (m_cycle_total)
    );
endmodule

// ----- dv/tb_prescaled_reload_timer_bank_unit.sv -----
// ---------------------------------------------------------------------------
// tb_prescaled_reload_timer_bank_unit
// Self-checking bench for the timer bank: directed corner items, stopped-bank
// and total-wrap runs, a back-pressure run and random item streams under several
// idling phases, each result compared field by field with a behavioral bank model.
// ---------------------------------------------------------------------------
module tb_prescaled_reload_timer_bank_unit;
    import prtb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NT = NumTimersDefault;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [7:0]  fired;
        logic [31:0] count;
        logic [31:0] period;
        logic [31:0] reload;
        logic [15:0] prescale;
        logic        expired;
        logic        on;
        logic [63:0] total;
    } timer_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_mode = '0;
    logic [2:0]  s_timer_index = '0;
    logic [31:0] s_elapsed_cycles = '0;
    logic [31:0] s_period_value = '0;
    logic [15:0] s_prescale_value = '0;
    logic        s_enable_flag = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_fired_mask;
    logic [31:0] m_counter_value;
    logic [31:0] m_period_out;
    logic [31:0] m_reload_out;
    logic [15:0] m_prescale_out;
    logic        m_expired_out;
    logic        m_timer_on_out;
    logic [63:0] m_cycle_total;

    // Bench copy of the bank state.
    logic [31:0] mdl_count [NT];
    logic [31:0] mdl_period [NT];
    logic [31:0] mdl_reload [NT];
    logic [15:0] mdl_prescale [NT];
    logic        mdl_on [NT];
    logic        mdl_expired [NT];
    logic [63:0] mdl_total;
    logic        mdl_run;

    timer_result_t pending_results[$];
    int errors = 0;
    int results_seen = 0;
    int fired_seen = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit long_hold = 1'b0;

    always #6 aclk = ~aclk;

    prescaled_reload_timer_bank_unit #(.NUM_TIMERS(NT)) i_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_timer_index(s_timer_index), .s_elapsed_cycles(s_elapsed_cycles),
        .s_period_value(s_period_value), .s_prescale_value(s_prescale_value),
        .s_enable_flag(s_enable_flag), .m_valid(m_valid), .m_ready(m_ready),
        .m_fired_mask(m_fired_mask), .m_counter_value(m_counter_value),
        .m_period_out(m_period_out), .m_reload_out(m_reload_out),
        .m_prescale_out(m_prescale_out), .m_expired_out(m_expired_out),
        .m_timer_on_out(m_timer_on_out), .m_cycle_total(m_cycle_total)
    );

    task automatic bank_model_reset();
        for (int t = 0; t < NT; t++) begin
            mdl_count[t] = '0;
            mdl_period[t] = '0;
            mdl_reload[t] = '0;
            mdl_prescale[t] = 16'd1;
            mdl_on[t] = 1'b0;
            mdl_expired[t] = 1'b0;
        end
        mdl_total = '0;
        mdl_run = 1'b1;
    endtask

    // Computes the result of one item and updates the bench state.
    function automatic timer_result_t predict_timer_item(logic [2:0] mode, logic [2:0] idx,
            logic [31:0] cyc, logic [31:0] per, logic [15:0] pre, logic en);
        timer_result_t r;
        logic [31:0] dv, prev, sum;
        logic in_range;
        r = '0;
        in_range = (idx < NT);
        case (mode)
            MODE_ADVANCE: begin
                if (mdl_run) begin
                    mdl_total = mdl_total + {32'd0, cyc};
                    for (int t = 0; t < NT; t++) begin
                        if (mdl_on[t] && mdl_period[t] != 0) begin
                            dv = (mdl_prescale[t] == 0) ? 32'd1 : {16'd0, mdl_prescale[t]};
                            prev = mdl_count[t];
                            sum = prev + cyc / dv;
                            if (sum >= mdl_period[t]) begin
                                mdl_expired[t] = 1'b1;
                                mdl_count[t] = mdl_reload[t];
                                r.fired[t] = 1'b1;
                            end else if (sum < prev) begin
                                mdl_count[t] = mdl_period[t] - 32'd1;
                            end else begin
                                mdl_count[t] = sum;
                            end
                        end
                    end
                end
            end
            MODE_CONFIGURE: begin
                if (in_range) begin
                    mdl_period[idx] = per;
                    mdl_reload[idx] = per;
                    mdl_count[idx] = '0;
                    mdl_on[idx] = 1'b1;
                    mdl_expired[idx] = 1'b0;
                end
            end
            MODE_ENABLE: begin
                if (in_range) begin
                    mdl_on[idx] = en;
                    if (en) begin
                        mdl_count[idx] = mdl_reload[idx];
                        mdl_expired[idx] = 1'b0;
                    end
                end
            end
            MODE_PRESCALE: begin
                if (in_range) mdl_prescale[idx] = pre;
            end
            MODE_RESET: begin
                mdl_total = '0;
                for (int t = 0; t < NT; t++) begin
                    mdl_count[t] = mdl_reload[t];
                    mdl_expired[t] = 1'b0;
                end
            end
            MODE_READ: begin
                if (in_range) begin
                    r.count = mdl_count[idx];
                    r.period = mdl_period[idx];
                    r.reload = mdl_reload[idx];
                    r.prescale = mdl_prescale[idx];
                    r.expired = mdl_expired[idx];
                    r.on = mdl_on[idx];
                end
            end
            default: ;
        endcase
        r.total = mdl_total;
        return r;
    endfunction

    // Offers one item, holding it until the transfer, then books the result.
    // Valid stays high on return; the next item or an idle stretch replaces it.
    task automatic send_timer_item(logic [2:0] mode, logic [2:0] idx, logic [31:0] cyc,
            logic [31:0] per, logic [15:0] pre, logic en);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_timer_index <= idx;
        s_elapsed_cycles <= cyc;
        s_period_value <= per;
        s_prescale_value <= pre;
        s_enable_flag <= en;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(predict_timer_item(mode, idx, cyc, per, pre, en));
        @(negedge aclk);
    endtask

    // Lets the bank drain completely, then pauses for longer than its longest item takes.
    task automatic drain_bank();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    task automatic write_run(logic value);
        drain_bank();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        mdl_run = value;
    endtask

    // Result checker: compares every transfer with the oldest expectation.
    always @(posedge aclk) begin
        timer_result_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_fired_mask, m_counter_value, m_period_out, m_reload_out,
                    m_prescale_out, m_expired_out, m_timer_on_out, m_cycle_total};
            results_seen++;
            if (m_fired_mask != 0) fired_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.fired !== want.fired)
                    $display("%0t: fired_mask exp %h got %h", $time, want.fired, got.fired);
                if (got.count !== want.count)
                    $display("%0t: counter exp %h got %h", $time, want.count, got.count);
                if (got.period !== want.period)
                    $display("%0t: period exp %h got %h", $time, want.period, got.period);
                if (got.reload !== want.reload)
                    $display("%0t: reload exp %h got %h", $time, want.reload, got.reload);
                if (got.prescale !== want.prescale)
                    $display("%0t: prescale exp %h got %h", $time, want.prescale,
                             got.prescale);
                if (got.expired !== want.expired)
                    $display("%0t: expired exp %b got %b", $time, want.expired, got.expired);
                if (got.on !== want.on)
                    $display("%0t: timer_on exp %b got %b", $time, want.on, got.on);
                if (got.total !== want.total)
                    $display("%0t: cycle_total exp %h got %h", $time, want.total, got.total);
                if (got !== want) errors++;
            end
        end
    end

    // Receiver ready: random stalls, or a long counted hold when requested.
    always @(negedge aclk) begin
        int hold;
        if (long_hold) begin
            m_ready <= 1'b0;
            for (hold = 0; hold < 600; hold++) @(negedge aclk);
            long_hold = 1'b0;
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: counts cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_prescaled_reload_timer_bank_unit: FAIL");
            $finish;
        end
    end

    // Random item generator: mostly meaningful timer traffic.
    task automatic send_random_item();
        int pick;
        logic [31:0] cyc, per;
        logic [15:0] pre;
        logic [2:0] idx;
        logic [2:0] mode;
        pick = $urandom_range(99);
        idx = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(NT - 1));
        cyc = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(300));
        per = ($urandom_range(7) == 0) ? $urandom : 32'($urandom_range(400));
        pre = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(4));
        if (pick < 45) mode = MODE_ADVANCE;
        else if (pick < 57) mode = MODE_CONFIGURE;
        else if (pick < 65) mode = MODE_ENABLE;
        else if (pick < 72) mode = MODE_PRESCALE;
        else if (pick < 75) mode = MODE_RESET;
        else if (pick < 97) mode = MODE_READ;
        else mode = 3'(6 + $urandom_range(1));
        send_timer_item(mode, idx, cyc, per, pre, 1'($urandom));
    endtask

    task automatic test_directed();
        send_timer_item(MODE_READ, 3'd0, '0, '0, '0, 1'b0);
        send_timer_item(MODE_CONFIGURE, 3'd0, '0, 32'd10, '0, 1'b0);
        send_timer_item(MODE_CONFIGURE, 3'd1, '0, 32'hFFFF_FFFF, '0, 1'b0);
        send_timer_item(MODE_CONFIGURE, 3'd2, '0, 32'd0, '0, 1'b0);
        send_timer_item(MODE_CONFIGURE, 3'd3, '0, 32'd1000, '0, 1'b0);
        send_timer_item(MODE_PRESCALE, 3'd0, '0, '0, 16'd0, 1'b0);     // zero prescaler
        send_timer_item(MODE_PRESCALE, 3'd3, '0, '0, 16'hFFFF, 1'b0);
        send_timer_item(MODE_ADVANCE, 3'd0, 32'd9, '0, '0, 1'b0);
        send_timer_item(MODE_ADVANCE, 3'd0, 32'd55, '0, '0, 1'b0);     // many periods
        send_timer_item(MODE_ADVANCE, 3'd0, 32'hFFFF_FFFF, '0, '0, 1'b0);
        send_timer_item(MODE_ADVANCE, 3'd0, 32'hFFFF_FFFE, '0, '0, 1'b0); // wrap on timer 1
        send_timer_item(MODE_READ, 3'd0, '0, '0, '0, 1'b0);            // sticky expired
        send_timer_item(MODE_READ, 3'd1, '0, '0, '0, 1'b0);
        send_timer_item(MODE_READ, 3'd3, '0, '0, '0, 1'b0);
        send_timer_item(MODE_ENABLE, 3'd0, '0, '0, '0, 1'b0);
        send_timer_item(MODE_ADVANCE, 3'd0, 32'd100, '0, '0, 1'b0);
        send_timer_item(MODE_ENABLE, 3'd0, '0, '0, '0, 1'b1);
        send_timer_item(MODE_CONFIGURE, 3'd7, '0, 32'd5, '0, 1'b0);    // out of range
        send_timer_item(MODE_ENABLE, 3'd4, '0, '0, '0, 1'b1);
        send_timer_item(MODE_PRESCALE, 3'd5, '0, '0, 16'd7, 1'b0);
        send_timer_item(MODE_READ, 3'd6, '0, '0, '0, 1'b0);
        send_timer_item(3'd6, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        send_timer_item(3'd7, 3'd0, '0, '0, '0, 1'b0);
        send_timer_item(MODE_RESET, 3'd0, '0, '0, '0, 1'b0);
        send_timer_item(MODE_READ, 3'd3, '0, '0, '0, 1'b0);
    endtask

    // Bank stopped: advances must leave everything unchanged.
    task automatic test_stopped_bank();
        write_run(1'b0);
        for (int i = 0; i < 20; i++) send_random_item();
        write_run(1'b1);
    endtask

    // Pushes the 64-bit total toward its wrap with large advances.
    task automatic test_total_wrap();
        for (int i = 0; i < 20; i++)
            send_timer_item(MODE_ADVANCE, 3'd0, 32'hFFFF_FFFF, '0, '0, 1'b0);
    endtask

    task automatic test_random_phase(int snd, int rcv, int count);
        send_idle_pct = snd;
        recv_stall_pct = rcv;
        for (int i = 0; i < count; i++) send_random_item();
    endtask

    // Long receiver hold while items keep coming, then a full pause.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        long_hold = 1'b1;
        for (int i = 0; i < 30; i++) send_random_item();
        drain_bank();
    endtask

    initial begin
        bank_model_reset();
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_stopped_bank();
        test_total_wrap();
        test_random_phase(0, 0, 400);
        test_backpressure();
        write_run(1'b0);
        test_random_phase(65, 0, 150);
        write_run(1'b1);
        test_random_phase(65, 0, 400);
        test_random_phase(0, 65, 400);
        test_random_phase(6, 6, 600);
        drain_bank();
        $display("Ran directed corners, stopped-bank and wrap checks, and random phases.");
        $display("Checked %0d results, %0d of them with fired timers; %0d errors.",
                 results_seen, fired_seen, errors);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("tb_prescaled_reload_timer_bank_unit: PASS");
        end else begin
            $display("tb_prescaled_reload_timer_bank_unit: FAIL");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/prtb_pkg.sv
rtl/core/prtb_ctrl.sv
rtl/core/prtb_div.sv
rtl/core/prtb_dp.sv
rtl/core/prescaled_reload_timer_bank_unit.sv
dv/tb_prescaled_reload_timer_bank_unit.sv
